// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the chunk reassembly RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, skipped while reset is high
`define CRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked during reset too
`define CRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// crt_pkg
// Constants, types and helpers for the chunk reassembly tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package crt_pkg;

  localparam int CHUNK_BYTES   = 1024;
  localparam int MAX_CHUNKS    = 256;
  localparam int STORE_DEPTH   = CHUNK_BYTES * MAX_CHUNKS;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = MAX_CHUNKS / MAP_WORD_BITS;

  localparam int CHUNK_W    = $clog2(MAX_CHUNKS);
  localparam int OFF_W      = $clog2(CHUNK_BYTES);
  localparam int COUNT_W    = CHUNK_W + 1;
  localparam int LAST_W     = OFF_W + 1;
  localparam int ADDR_W     = CHUNK_W + OFF_W;
  localparam int MAP_ADDR_W = $clog2(MAP_WORDS);
  localparam int BIT_W      = $clog2(MAP_WORD_BITS);

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic REG_TOTAL_CHUNKS     = 1'b0;
  localparam logic REG_LAST_CHUNK_BYTES = 1'b1;

  typedef struct packed {
    logic                     rd_en;
    logic [MAP_ADDR_W-1:0]    rd_addr;
    logic                     wr_en;
    logic [MAP_ADDR_W-1:0]    wr_addr;
    logic [MAP_WORD_BITS-1:0] wr_data;
  } map_req_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } zero_find_t;

  function automatic zero_find_t find_zero(input logic [MAP_WORD_BITS-1:0] word);
    zero_find_t res;
    res.found = 1'b0;
    res.pos   = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.found = 1'b1;
        res.pos   = BIT_W'(i);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crt_loaded_map.sv =====
// ----------------------------------------------------------------------------
// crt_loaded_map
// Loaded-chunk bitmap: word memory with registered read and per-word valid
// flags, so that reset clears the map at once.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_loaded_map (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire crt_pkg::map_req_t                req,
  output logic [crt_pkg::MAP_WORD_BITS-1:0]     rd_word
);
  import crt_pkg::*;

  logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]     word_valid;
  logic [MAP_WORD_BITS-1:0] mem_q;
  logic                     valid_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      map_mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q <= map_mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (req.wr_en) begin
        word_valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        valid_q <= word_valid[req.rd_addr];
      end
    end
  end

  assign rd_word = valid_q ? mem_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/chunk_reassembly_tracker.sv =====
// ----------------------------------------------------------------------------
// chunk_reassembly_tracker
// Rebuilds a file from numbered chunks one byte at a time, tracks loaded
// chunks in a bitmap, and reports the lowest missing chunk with each result.
//
// channel  signals                                                              dir
// command  start, busy, command, chunk_index, byte_offset, data_byte, chunk_end  in (busy out)
// result   done, accepted, read_byte, next_missing, all_loaded                   out
// config   cfg_valid, cfg_ready, cfg_index, cfg_data                             in (cfg_ready out)
//
// done rises after the item has passed through the EXEC and RESP states, and a new
// item is taken only once busy has fallen; the byte store and the bitmap word are
// read at the accepting edge and used in the following cycle.
// Completing the lowest missing chunk starts a search of the bitmap: it is
// searched one 32-bit word per cycle through the single map read port.
// Reset clears the per-word valid flags of the bitmap at once; no sweep.
// The receiver cannot stall; done is high for one cycle per result.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_reassembly_tracker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         command,
  input  wire logic [crt_pkg::CHUNK_W-1:0]  chunk_index,
  input  wire logic [crt_pkg::OFF_W-1:0]    byte_offset,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         chunk_end,
  output logic                              done,
  output logic                              accepted,
  output logic [7:0]                        read_byte,
  output logic [crt_pkg::CHUNK_W-1:0]       next_missing,
  output logic                              all_loaded,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_index,
  input  wire logic [crt_pkg::LAST_W-1:0]   cfg_data
);
  import crt_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t                   state, state_next;
  logic [COUNT_W-1:0]       total_chunks;
  logic [LAST_W-1:0]        last_chunk_bytes;
  logic [COUNT_W-1:0]       eff_count;
  logic [COUNT_W-1:0]       miss_all, miss_all_next;
  logic [MAP_ADDR_W-1:0]    scan_w, scan_w_next;
  logic                     cmd_q, end_q, acc_q;
  logic [CHUNK_W-1:0]       chunk_q;
  logic [OFF_W-1:0]         off_q;
  logic [7:0]               rd_q, rd_next;
  logic [7:0]               file_mem [STORE_DEPTH];
  logic [7:0]               file_q;
  logic [ADDR_W-1:0]        file_addr;
  logic                     take, acc_in;
  map_req_t                 map_req;
  logic [MAP_WORD_BITS-1:0] map_word, new_word;
  logic [MAP_ADDR_W-1:0]    cur_w;
  logic [BIT_W-1:0]         cur_bit;
  logic                     mark, loaded, in_file;
  zero_find_t               zf;

  crt_loaded_map u_map (
    .clk     (clk),
    .rst     (rst),
    .req     (map_req),
    .rd_word (map_word)
  );

  assign eff_count = (total_chunks > COUNT_W'(MAX_CHUNKS)) ? COUNT_W'(MAX_CHUNKS)
                                                           : total_chunks;
  assign busy      = (state != ST_IDLE);
  assign take      = start && !busy;
  assign acc_in    = {1'b0, chunk_index} < eff_count;
  assign cfg_ready = 1'b1;
  assign file_addr = {chunk_index, byte_offset};

  always_ff @(posedge clk) begin
    if (take && acc_in && command == CMD_STORE) begin
      file_mem[file_addr] <= data_byte;
    end
    if (take && command == CMD_READ) begin
      file_q <= file_mem[file_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_chunks     <= COUNT_W'(1);
      last_chunk_bytes <= LAST_W'(CHUNK_BYTES);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TOTAL_CHUNKS:     total_chunks     <= cfg_data[COUNT_W-1:0];
        REG_LAST_CHUNK_BYTES: last_chunk_bytes <= cfg_data;
        default:              ;
      endcase
    end
  end

  assign cur_w    = chunk_q[CHUNK_W-1 -: MAP_ADDR_W];
  assign cur_bit  = chunk_q[BIT_W-1:0];
  assign loaded   = map_word[cur_bit];
  assign new_word = map_word | (MAP_WORD_BITS'(1) << cur_bit);
  assign mark     = (cmd_q == CMD_STORE) && acc_q && end_q;
  assign in_file  = (({1'b0, chunk_q} + COUNT_W'(1)) < eff_count) ||
                    ({1'b0, off_q} < last_chunk_bytes);

  always_comb begin
    state_next    = state;
    miss_all_next = miss_all;
    scan_w_next   = scan_w;
    rd_next       = rd_q;
    map_req       = '0;
    zf            = find_zero(state == ST_SCAN ? map_word : new_word);
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          map_req.rd_en   = 1'b1;
          map_req.rd_addr = chunk_index[CHUNK_W-1 -: MAP_ADDR_W];
          state_next      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rd_next    = ((cmd_q == CMD_READ) && acc_q && loaded && in_file) ? file_q : 8'd0;
        state_next = ST_RESP;
        if (mark) begin
          map_req.wr_en   = 1'b1;
          map_req.wr_addr = cur_w;
          map_req.wr_data = new_word;
          if ({1'b0, chunk_q} == miss_all) begin
            if (zf.found) begin
              miss_all_next = {1'b0, cur_w, zf.pos};
            end else if (cur_w == MAP_ADDR_W'(MAP_WORDS - 1)) begin
              miss_all_next = COUNT_W'(MAX_CHUNKS);
            end else begin
              map_req.rd_en   = 1'b1;
              map_req.rd_addr = cur_w + MAP_ADDR_W'(1);
              scan_w_next     = cur_w + MAP_ADDR_W'(1);
              state_next      = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (zf.found) begin
          miss_all_next = {1'b0, scan_w, zf.pos};
          state_next    = ST_RESP;
        end else if (scan_w == MAP_ADDR_W'(MAP_WORDS - 1)) begin
          miss_all_next = COUNT_W'(MAX_CHUNKS);
          state_next    = ST_RESP;
        end else begin
          map_req.rd_en   = 1'b1;
          map_req.rd_addr = scan_w + MAP_ADDR_W'(1);
          scan_w_next     = scan_w + MAP_ADDR_W'(1);
        end
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      miss_all <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      miss_all <= miss_all_next;
      done     <= (state == ST_RESP);
    end
  end

  always_ff @(posedge clk) begin
    scan_w <= scan_w_next;
    rd_q   <= rd_next;
    if (take) begin
      cmd_q   <= command;
      chunk_q <= chunk_index;
      off_q   <= byte_offset;
      end_q   <= chunk_end;
      acc_q   <= acc_in;
    end
    if (state == ST_RESP) begin
      accepted     <= acc_q;
      read_byte    <= rd_q;
      next_missing <= (miss_all < eff_count) ? miss_all[CHUNK_W-1:0] : '0;
      all_loaded   <= !(miss_all < eff_count);
    end
  end

  `CRT_ASSERT(a_done_single, done |=> !done, "done strobe lasted more than one cycle")
  `CRT_ASSERT(a_take_busy, take |=> busy, "accepted transaction did not raise busy")
  `CRT_ASSERT(a_all_no_miss, done && all_loaded |-> next_missing == '0, "all loaded with a missing chunk")
  `CRT_ASSERT(a_reject_zero, done && !accepted |-> read_byte == 8'd0, "rejected transaction returned data")

endmodule

`default_nettype wire
